[hw/rtl/sorted_key_table_assert.svh]
// Assertion macros for the RTL of the sorted key table.
// Every check is clocked on i_clk and held off while i_rst_n is low.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define SKT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/skt_pkg.sv]
`timescale 1ns / 1ps

package skt_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_LOOKUP  = 3'd2,
        OP_READ    = 3'd3,
        OP_NEXT_ID = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_RANK  = 2'd3
    } t_status;

    // Command broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    typedef struct packed {
        t_op                 op;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [IDX_W-1:0]    rank;
    } t_in_word;

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    found_rank;
        logic [KEY_W-1:0]    found_key;
        logic [HANDLE_W-1:0] found_handle;
        logic [CNT_W-1:0]    entry_count;
    } t_out_word;

    typedef struct packed {
        t_cell_op            op;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    occ;
    } t_cell_cmd;

    // What a cell shows its neighbors and the top level
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic                le;
        logic                lt;
    } t_cell_out;

endpackage

[hw/rtl/sorted_key_table.sv]
`timescale 1ns / 1ps

// Sorted key table: up to DEPTH key/handle entries kept in ascending key order
// in a row of cells, one entry per cell.
// Input channel: i_in_valid / o_in_stall carry one command word (op, key,
// handle, rank). Output channel: o_out_valid / i_out_stall carry one result
// word (status, rank, key, handle, entry count) for every command.
// Each command passes through a compare state, in which every cell compares
// its key with the command key, and an execute state, in which the cells
// shift or load and the result is registered. A new command is taken in the
// execute state, while the result of the last command is being registered.
// If the receiver stalls, the pending result holds and the next command waits
// in its compare cycle until the output word is taken; o_in_stall is high
// during that cycle.
// Reset empties the table and clears the top id; entry contents are not
// cleared, only the fill count.
module sorted_key_table
    import skt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

`include "sorted_key_table_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    t_state           r_state;
    t_in_word         r_req;
    t_out_word        r_out;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_occ;
    logic [KEY_W-1:0] r_top;

    logic [CNT_W-1:0] n_occ;
    logic [KEY_W-1:0] n_top;
    t_out_word        n_out;

    t_cell_cmd        w_cmd;
    t_cell_out        w_cell [DEPTH];

    logic [DEPTH-1:0] w_ins_pt;
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_rd;
    logic [DEPTH-1:0] w_sel;
    logic             w_full;
    logic             w_hit;
    logic             w_rank_ok;
    logic             w_ins_ok;
    logic             w_del_ok;
    logic             w_acc;
    logic [IDX_W-1:0]    w_enc;
    logic [KEY_W-1:0]    w_sel_key;
    logic [HANDLE_W-1:0] w_sel_handle;

    assign o_in_stall  = (r_state == S_CMP);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // row of cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_out w_l;
        t_cell_out w_r;
        if (gi == 0) begin : g_first
            assign w_l = '{key: '0, handle: '0, le: 1'b1, lt: 1'b1};
        end else begin : g_mid_l
            assign w_l = w_cell[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_r = w_cell[gi];
        end else begin : g_mid_r
            assign w_r = w_cell[gi+1];
        end
        skt_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (CNT_W'(gi)),
            .i_cmd   (w_cmd),
            .i_left  (w_l),
            .i_right (w_r),
            .o_cell  (w_cell[gi])
        );
    end

    // per-cell boundary flags, one-hot select and result mux
    always_comb begin
        w_full    = (r_occ == CNT_W'(DEPTH));
        w_rank_ok = (CNT_W'(r_req.rank) < r_occ);
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                w_ins_pt[i] = !w_cell[i].le;
                w_match[i]  = !w_cell[i].lt && w_cell[i].le;
            end else begin
                w_ins_pt[i] = !w_cell[i].le && w_cell[i-1].le;
                w_match[i]  = !w_cell[i].lt && w_cell[i].le && w_cell[i-1].lt;
            end
            w_rd[i] = (r_req.rank == IDX_W'(i));
        end
        w_hit = |w_match;

        case (r_req.op)
            OP_INSERT: w_sel = w_ins_pt;
            OP_READ:   w_sel = w_rd;
            default:   w_sel = w_match;
        endcase

        w_enc        = '0;
        w_sel_key    = '0;
        w_sel_handle = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_sel[i]) begin
                w_enc        = w_enc | IDX_W'(i);
                w_sel_key    = w_sel_key | w_cell[i].key;
                w_sel_handle = w_sel_handle | w_cell[i].handle;
            end
        end
    end

    // operation decode and next state of the table
    always_comb begin
        w_ins_ok = (r_state == S_EXEC) && (r_req.op == OP_INSERT) && !w_full;
        w_del_ok = (r_state == S_EXEC) && (r_req.op == OP_REMOVE) && w_hit;

        n_occ = r_occ;
        n_top = r_top;
        n_out = '{status: ST_OK, found_rank: '0, found_key: '0,
                  found_handle: '0, entry_count: '0};

        case (r_req.op)
            OP_INSERT: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_occ              = r_occ + CNT_W'(1);
                    n_out.found_rank   = w_enc;
                    n_out.found_key    = r_req.key;
                    n_out.found_handle = r_req.handle;
                    if (r_req.key > r_top) begin
                        n_top = r_req.key;
                    end
                end
            end
            OP_REMOVE, OP_LOOKUP: begin
                if (!w_hit) begin
                    n_out.status = ST_NOT_FOUND;
                end else begin
                    n_out.found_rank   = w_enc;
                    n_out.found_key    = r_req.key;
                    n_out.found_handle = w_sel_handle;
                    if (r_req.op == OP_REMOVE) begin
                        n_occ = r_occ - CNT_W'(1);
                    end
                end
            end
            OP_READ: begin
                if (!w_rank_ok) begin
                    n_out.status = ST_BAD_RANK;
                end else begin
                    n_out.found_rank   = r_req.rank;
                    n_out.found_key    = w_sel_key;
                    n_out.found_handle = w_sel_handle;
                end
            end
            OP_NEXT_ID: begin
                n_top           = r_top + KEY_W'(1);
                n_out.found_key = n_top;
            end
            default: begin
            end
        endcase
        n_out.entry_count = n_occ;

        w_cmd.key    = r_req.key;
        w_cmd.handle = r_req.handle;
        w_cmd.occ    = r_occ;
        if (r_state == S_CMP) begin
            w_cmd.op = CELL_CMP;
        end else if (w_ins_ok) begin
            w_cmd.op = CELL_INS;
        end else if (w_del_ok) begin
            w_cmd.op = CELL_DEL;
        end else begin
            w_cmd.op = CELL_HOLD;
        end
    end

    // sequencer, table counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_occ       <= '0;
            r_top       <= '0;
        end else begin
            if (w_acc) begin
                r_req <= i_in_word;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // move on only once the output word is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_occ       <= n_occ;
                    r_top       <= n_top;
                    r_out       <= n_out;
                    r_out_valid <= 1'b1;
                    r_state     <= w_acc ? S_CMP : S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SKT_ASSERT_IMPL(a_exec_out_free, r_state == S_EXEC, !(r_out_valid && i_out_stall),
        "result overwrites a word still waiting on the output")
    `SKT_ASSERT_NEXT(a_exec_gives_word, r_state == S_EXEC, r_out_valid,
        "no result word after an execute cycle")
    `SKT_ASSERT_IMPL(a_match_onehot, r_state == S_EXEC, $onehot0(w_match),
        "more than one cell claims the key match")
    `SKT_ASSERT_IMPL(a_ins_point_onehot, w_ins_ok, $onehot(w_ins_pt),
        "insert point is not a single cell")
    `SKT_ASSERT_NEXT(a_ins_count, w_ins_ok, r_occ == $past(r_occ) + CNT_W'(1),
        "fill count did not step on insert")

endmodule

[hw/rtl/skt_cell.sv]
`timescale 1ns / 1ps

module skt_cell
    import skt_pkg::*;
(
    input  logic                i_clk,
    input  logic [CNT_W-1:0]    i_idx,
    input  t_cell_cmd           i_cmd,
    input  t_cell_out           i_left,
    input  t_cell_out           i_right,
    output t_cell_out           o_cell
);

    logic [KEY_W-1:0]    r_key;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_le;
    logic                r_lt;
    logic                w_valid;

    // entries below the fill count are live
    assign w_valid = i_idx < i_cmd.occ;

    // compare against the broadcast key, then shift or load on command
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_CMP: begin
                r_le <= w_valid && (r_key <= i_cmd.key);
                r_lt <= w_valid && (r_key < i_cmd.key);
            end
            CELL_INS: begin
                // cells at or past the insert point move up by one
                if (!r_le) begin
                    if (i_left.le) begin
                        r_key    <= i_cmd.key;
                        r_handle <= i_cmd.handle;
                    end else begin
                        r_key    <= i_left.key;
                        r_handle <= i_left.handle;
                    end
                end
            end
            CELL_DEL: begin
                // cells at or past the removed entry pull from the right
                if (!r_lt) begin
                    r_key    <= i_right.key;
                    r_handle <= i_right.handle;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_cell = '{key: r_key, handle: r_handle, le: r_le, lt: r_lt};

endmodule

[sim/skt_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the sorted key table, keeps its own copy of the
// table, and compares every result word with the word it predicts.
module skt_checker
    import skt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    // shadow table: sorted keys, handles beside them, fill count, top id
    logic [KEY_W-1:0]    key_mem    [DEPTH];
    logic [HANDLE_W-1:0] handle_mem [DEPTH];
    int                  fill = 0;
    logic [KEY_W-1:0]    id_top = '0;

    t_out_word result_words_due [$];
    int        fails = 0;
    int        checked = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        fails++;
    endtask

    // first rank with key >= k, or > k when past_equal is set
    function automatic int find_rank(input logic [KEY_W-1:0] k, input bit past_equal);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = fill;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (past_equal ? (key_mem[mid] <= k) : (key_mem[mid] < k))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // apply one command word to the shadow table, return the result word
    function automatic t_out_word run_table_op(input t_in_word w);
        t_out_word r;
        int        pos;
        int        i;
        r        = '0;
        r.status = ST_OK;
        case (w.op)
            OP_INSERT: begin
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // equal keys stay ahead of the new entry
                    pos = find_rank(w.key, 1'b1);
                    for (i = fill; i > pos; i--) begin
                        key_mem[i]    = key_mem[i-1];
                        handle_mem[i] = handle_mem[i-1];
                    end
                    key_mem[pos]    = w.key;
                    handle_mem[pos] = w.handle;
                    fill++;
                    if (w.key > id_top)
                        id_top = w.key;
                    r.found_rank   = pos[IDX_W-1:0];
                    r.found_key    = w.key;
                    r.found_handle = w.handle;
                end
            end
            OP_REMOVE, OP_LOOKUP: begin
                // lowest-ranked match among duplicates
                pos = find_rank(w.key, 1'b0);
                if (pos >= fill || key_mem[pos] != w.key) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found_rank   = pos[IDX_W-1:0];
                    r.found_key    = w.key;
                    r.found_handle = handle_mem[pos];
                    if (w.op == OP_REMOVE) begin
                        for (i = pos; i + 1 < fill; i++) begin
                            key_mem[i]    = key_mem[i+1];
                            handle_mem[i] = handle_mem[i+1];
                        end
                        fill--;
                    end
                end
            end
            OP_READ: begin
                if (int'(w.rank) >= fill) begin
                    r.status = ST_BAD_RANK;
                end else begin
                    r.found_rank   = w.rank;
                    r.found_key    = key_mem[w.rank];
                    r.found_handle = handle_mem[w.rank];
                end
            end
            OP_NEXT_ID: begin
                // wraps to zero past all ones
                id_top      = id_top + KEY_W'(1);
                r.found_key = id_top;
            end
            default: begin
                // undefined codes leave everything alone
            end
        endcase
        r.entry_count = CNT_W'(fill);
        return r;
    endfunction

    // result side is checked before the command side is predicted
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            fill   = 0;
            id_top = '0;
            result_words_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_words_due.size() == 0) begin
                    report_mismatch("result word with none due",
                                    64'(i_out_word.found_key), '0);
                end else begin
                    want = result_words_due.pop_front();
                    checked++;
                    if (i_out_word.status !== want.status)
                        report_mismatch("status", 64'(i_out_word.status),
                                        64'(want.status));
                    if (i_out_word.found_rank !== want.found_rank)
                        report_mismatch("found_rank", 64'(i_out_word.found_rank),
                                        64'(want.found_rank));
                    if (i_out_word.found_key !== want.found_key)
                        report_mismatch("found_key", 64'(i_out_word.found_key),
                                        64'(want.found_key));
                    if (i_out_word.found_handle !== want.found_handle)
                        report_mismatch("found_handle", 64'(i_out_word.found_handle),
                                        64'(want.found_handle));
                    if (i_out_word.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(i_out_word.entry_count),
                                        64'(want.entry_count));
                end
            end
            if (i_in_valid && !i_in_stall)
                result_words_due.push_back(run_table_op(i_in_word));
        end
        o_pending    <= result_words_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import skt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_LEN   = 100;
    localparam int N_PHASES    = 7;
    localparam int DRAIN_WAIT  = 20;

    localparam int PH_FILL  = 0;
    localparam int PH_MIXED = 1;
    localparam int PH_DRAIN = 2;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    int fail_count;
    int pending;
    int checked;
    int cycles = 0;
    int next_gap;
    bit send_idle;
    bit hold_request;
    int op_tally [8];

    // phase plan for the random part; pressure goes into the sixth
    int phase_plan [N_PHASES] = '{PH_FILL, PH_MIXED, PH_DRAIN, PH_FILL,
                                  PH_MIXED, PH_FILL, PH_DRAIN};

    sorted_key_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    skt_checker u_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, pending);
            $display("** sorted_key_table: FAILED **");
            $finish;
        end
    end

    function automatic t_in_word make_word(input t_op op, input logic [KEY_W-1:0] key,
                                           input logic [HANDLE_W-1:0] handle,
                                           input logic [IDX_W-1:0] rank);
        t_in_word w;
        w.op     = op;
        w.key    = key;
        w.handle = handle;
        w.rank   = rank;
        return w;
    endfunction

    // mostly a small key range so duplicates pile up and removes hit
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return KEY_W'($urandom_range(0, 31));
        if (r < 72) begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return '1;
                default: return {{(KEY_W-1){1'b1}}, 1'b0};
            endcase
        end
        return KEY_W'($urandom());
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return HANDLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_rank();
        if ($urandom_range(0, 1))
            return IDX_W'($urandom_range(0, DEPTH - 1));
        return IDX_W'($urandom_range(0, 15));
    endfunction

    // op mix per phase, cumulative percent thresholds
    function automatic t_op pick_op(input int phase);
        int r;
        int c_ins;
        int c_rem;
        int c_lkp;
        int c_rd;
        int c_nid;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL:  begin c_ins = 75; c_rem = 83; c_lkp = 90; c_rd = 95; c_nid = 98; end
            PH_DRAIN: begin c_ins = 10; c_rem = 70; c_lkp = 85; c_rd = 95; c_nid = 98; end
            default:  begin c_ins = 30; c_rem = 55; c_lkp = 75; c_rd = 90; c_nid = 97; end
        endcase
        if (r < c_ins) return OP_INSERT;
        if (r < c_rem) return OP_REMOVE;
        if (r < c_lkp) return OP_LOOKUP;
        if (r < c_rd)  return OP_READ;
        if (r < c_nid) return OP_NEXT_ID;
        return t_op'($urandom_range(5, 7));
    endfunction

    // offer one command word, hold it until taken, then draw the next gap
    task automatic send_word(input t_in_word w);
        if (next_gap > 0) begin
            in_valid <= 1'b0;
            repeat (next_gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        op_tally[w.op]++;
        if ($urandom_range(0, 39) == 0)
            send_idle = !send_idle;
        next_gap = send_idle ? $urandom_range(0, 16) : 0;
    endtask

    // receiver: random stall before each word, one long hold on request
    initial begin
        int  wait_n;
        bit  recv_idle;
        bit  hold_done;
        recv_idle = 1'b1;
        hold_done = 1'b0;
        out_stall = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_n = recv_idle ? $urandom_range(0, 16) : 0;
            if (hold_request && !hold_done) begin
                wait_n    = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            if ($urandom_range(0, 39) == 0)
                recv_idle = !recv_idle;
        end
    end

    // stimulus and verdict
    initial begin
        int p;
        int n;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        next_gap     = 0;
        send_idle    = 1'b1;
        hold_request = 1'b0;
        foreach (op_tally[k]) op_tally[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates, wrap of the id
        send_word(make_word(OP_NEXT_ID, '0, '0, '0));
        send_word(make_word(OP_READ, '0, '0, '0));
        send_word(make_word(OP_LOOKUP, '0, '0, '0));
        send_word(make_word(OP_REMOVE, '1, '1, '1));
        send_word(make_word(OP_INSERT, '0, '0, '0));
        send_word(make_word(OP_INSERT, '1, '1, '1));
        send_word(make_word(OP_NEXT_ID, '0, '0, '0));
        send_word(make_word(OP_NEXT_ID, '1, '1, '1));
        send_word(make_word(OP_INSERT, 32'd5, 16'h1234, '0));
        send_word(make_word(OP_INSERT, 32'd5, 16'hABCD, '0));
        send_word(make_word(OP_INSERT, 32'd5, 16'h0001, '0));
        send_word(make_word(OP_LOOKUP, 32'd5, '0, '0));
        send_word(make_word(OP_READ, '0, '0, 6'd2));
        send_word(make_word(OP_READ, '0, '0, '1));
        send_word(make_word(OP_READ, '0, '0, 6'd5));
        send_word(make_word(OP_READ, '0, '0, 6'd4));
        send_word(make_word(OP_REMOVE, 32'd5, '0, '0));
        send_word(make_word(OP_LOOKUP, 32'd5, '0, '0));
        send_word(make_word(OP_LOOKUP, 32'd6, '0, '0));
        send_word(make_word(OP_REMOVE, '0, '0, '0));
        send_word(make_word(t_op'(3'd5), pick_key(), pick_handle(), pick_rank()));
        send_word(make_word(t_op'(3'd6), pick_key(), pick_handle(), pick_rank()));
        send_word(make_word(t_op'(3'd7), pick_key(), pick_handle(), pick_rank()));
        send_word(make_word(OP_REMOVE, '1, '0, '0));
        send_word(make_word(OP_INSERT, 32'h8000_0000, 16'h8000, '0));

        // random part in phases; fill phases run the table into full
        for (p = 0; p < N_PHASES; p++) begin
            for (n = 0; n < PHASE_LEN; n++) begin
                if (p == 5 && n == PHASE_LEN / 2)
                    hold_request = 1'b1;
                send_word(make_word(pick_op(phase_plan[p]), pick_key(), pick_handle(),
                                    pick_rank()));
            end
        end
        in_valid <= 1'b0;

        // drain outstanding result words, then let the pipe settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display({"ran %0d inserts, %0d removes, %0d lookups, %0d reads, ",
                  "%0d next ids, %0d undefined"},
                 op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_LOOKUP],
                 op_tally[OP_READ], op_tally[OP_NEXT_ID],
                 op_tally[5] + op_tally[6] + op_tally[7]);
        $display("%0d result words checked, one %0d-cycle receiver hold, %0d mismatches",
                 checked, LONG_HOLD, fail_count);
        if (fail_count == 0)
            $display("** sorted_key_table: PASSED **");
        else
            $display("** sorted_key_table: FAILED **");
        $finish;
    end

endmodule
